// ===== src/crc_checked_frame_deframer_unit_macros.svh =====
// ----------------------------------------------------------------------------
// crc checked frame deframer assertion macros
// shared concurrent assertion wrappers, clocked on clk_i, held off in reset
// ----------------------------------------------------------------------------
`ifndef CRC_CHECKED_FRAME_DEFRAMER_UNIT_MACROS_SVH
`define CRC_CHECKED_FRAME_DEFRAMER_UNIT_MACROS_SVH

// same-cycle implication
`define CFD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/cfd_pkg.sv =====
// ----------------------------------------------------------------------------
// cfd_pkg
// constants, result codes and byte-wide crc update functions of the deframer
// ----------------------------------------------------------------------------
package cfd_pkg;

  localparam logic [7:0]  SofByte    = 8'hA5;
  localparam logic [7:0]  Crc8PolyR  = 8'h8C;
  localparam logic [7:0]  Crc8Init   = 8'hFF;
  localparam logic [15:0] Crc16PolyR = 16'h8408;
  localparam logic [15:0] Crc16Init  = 16'hFFFF;
  localparam int unsigned WinDepth   = 4;
  localparam int unsigned FailWidth  = 15;
  localparam logic [FailWidth-1:0] FailMax = '1;

  typedef enum logic [1:0] {
    KindPayload = 2'd0,
    KindOk      = 2'd1,
    KindCrcFail = 2'd2,
    KindTrunc   = 2'd3
  } out_kind_e;

  // reflected crc-8, one byte per call
  function automatic logic [7:0] crc8_byte(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ Crc8PolyR) : (c >> 1);
    end
    return c;
  endfunction

  // reflected crc-16, one byte per call
  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ Crc16PolyR) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== src/crc_checked_frame_deframer_unit.sv =====
// ----------------------------------------------------------------------------
// crc_checked_frame_deframer_unit
// sof / crc-8 header / crc-16 frame deframer for a uart byte stream
//   input channel: one item per received byte (op_i = 0) or per line-idle
//   event (op_i = 1), taken when in_valid_i is high and in_stall_o is low
//   output channel: zero or one result item per input item; payload bytes
//   (kind 0) and end-of-frame status (ok, crc failure, truncated by idle)
//   timing: a result item shows on the outputs the cycle after it is taken
//   throughput: one item per cycle while in_stall_o is low; every header crc
//   is kept as running partials over the newest window bytes, so each item
//   costs one crc-8 and one crc-16 byte step per partial
//   stall: the result register holds while out_stall_i is high; the input is
//   stalled only while a held result is still waiting, so a free result
//   register never blocks the input
//   reset: hunting with an empty window, failure count zero, no result held
// ----------------------------------------------------------------------------
module crc_checked_frame_deframer_unit
  import cfd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input item channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 op_i,
  input  logic [7:0]           data_byte_i,
  // result item channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [1:0]           kind_o,
  output logic [7:0]           payload_byte_o,
  output logic [15:0]          byte_index_o,
  output logic [15:0]          command_id_o,
  output logic [7:0]           sequence_res_o,
  output logic [15:0]          payload_length_o,
  output logic [FailWidth-1:0] failure_count_o
);

`include "crc_checked_frame_deframer_unit_macros.svh"

  typedef enum logic [1:0] {
    PhHunt = 2'd0,
    PhCmd  = 2'd1,
    PhPay  = 2'd2,
    PhCrc  = 2'd3
  } phase_e;

  // control state
  phase_e               phase_q, phase_d;
  logic [2:0]           fill_q, fill_d;
  logic [15:0]          cnt_q, cnt_d;
  logic [15:0]          len_q, len_d;
  logic [7:0]           seq_q, seq_d;
  logic [15:0]          cmd_q, cmd_d;
  logic [15:0]          crc16_q, crc16_d;
  logic [7:0]           crc_lo_q, crc_lo_d;
  logic [FailWidth-1:0] fail_q, fail_d;

  // hunt window, oldest byte at index 0, plus crc partials where entry k
  // covers the newest k+1 window bytes
  logic [7:0]  win_q   [WinDepth];
  logic [7:0]  win_d   [WinDepth];
  logic [7:0]  part8_q [WinDepth];
  logic [7:0]  part8_d [WinDepth];
  logic [15:0] part16_q[WinDepth];
  logic [15:0] part16_d[WinDepth];

  // result register
  logic                 out_valid_q, out_valid_d;
  out_kind_e            kind_q;
  logic [7:0]           pbyte_q;
  logic [15:0]          idx_q;
  logic [15:0]          res_cmd_q;
  logic [7:0]           res_seq_q;
  logic [15:0]          res_len_q;
  logic [FailWidth-1:0] res_fail_q;

  logic        accept;
  logic        emit;
  out_kind_e   emit_kind;
  logic [7:0]  emit_byte;
  logic [15:0] emit_idx;
  logic        shift_win;
  logic [15:0] cnt_inc;
  logic        crc_ok;

  // the input waits only while a held result is blocked downstream
  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign cnt_inc    = cnt_q + 16'd1;
  assign crc_ok     = (crc_lo_q == crc16_q[7:0]) && (data_byte_i == crc16_q[15:8]);

  always_comb begin
    phase_d   = phase_q;
    fill_d    = fill_q;
    cnt_d     = cnt_q;
    len_d     = len_q;
    seq_d     = seq_q;
    cmd_d     = cmd_q;
    crc16_d   = crc16_q;
    crc_lo_d  = crc_lo_q;
    fail_d    = fail_q;
    emit      = 1'b0;
    emit_kind = KindPayload;
    emit_byte = 8'h00;
    emit_idx  = 16'h0000;
    shift_win = 1'b0;

    if (accept) begin
      if (op_i) begin
        // line idle: a partial frame is reported as truncated
        if (phase_q != PhHunt) begin
          if (fail_q != FailMax) fail_d = fail_q + 1'b1;
          emit      = 1'b1;
          emit_kind = KindTrunc;
        end
        phase_d = PhHunt;
        fill_d  = 3'd0;
        cnt_d   = 16'd0;
      end else begin
        unique case (phase_q)
          PhHunt: begin
            if (fill_q < 3'(WinDepth)) begin
              fill_d    = fill_q + 3'd1;
              shift_win = 1'b1;
            end else if (win_q[0] == SofByte && part8_q[WinDepth-1] == data_byte_i) begin
              // header locked: crc-16 covers the whole header incl. crc-8
              crc16_d = crc16_byte(part16_q[WinDepth-1], data_byte_i);
              len_d   = {win_q[2], win_q[1]};
              seq_d   = win_q[3];
              cmd_d   = 16'h0000;
              cnt_d   = 16'd0;
              fill_d  = 3'd0;
              phase_d = PhCmd;
            end else begin
              shift_win = 1'b1;
            end
          end
          PhCmd: begin
            crc16_d = crc16_byte(crc16_q, data_byte_i);
            if (cnt_q == 16'd0) begin
              cmd_d = {8'h00, data_byte_i};
              cnt_d = 16'd1;
            end else begin
              cmd_d   = {data_byte_i, cmd_q[7:0]};
              cnt_d   = 16'd0;
              phase_d = (len_q == 16'd0) ? PhCrc : PhPay;
            end
          end
          PhPay: begin
            crc16_d   = crc16_byte(crc16_q, data_byte_i);
            emit      = 1'b1;
            emit_kind = KindPayload;
            emit_byte = data_byte_i;
            emit_idx  = cnt_q;
            if (cnt_inc == len_q) begin
              cnt_d   = 16'd0;
              phase_d = PhCrc;
            end else begin
              cnt_d = cnt_inc;
            end
          end
          PhCrc: begin
            if (cnt_q == 16'd0) begin
              crc_lo_d = data_byte_i;
              cnt_d    = 16'd1;
            end else begin
              emit      = 1'b1;
              emit_kind = crc_ok ? KindOk : KindCrcFail;
              if (!crc_ok && fail_q != FailMax) fail_d = fail_q + 1'b1;
              phase_d = PhHunt;
              fill_d  = 3'd0;
              cnt_d   = 16'd0;
            end
          end
          default: phase_d = PhHunt;
        endcase
      end
    end
  end

  // new byte enters the window; partial k is partial k-1 grown by the new byte
  always_comb begin
    for (int k = 0; k < WinDepth; k++) begin
      win_d[k]    = win_q[k];
      part8_d[k]  = part8_q[k];
      part16_d[k] = part16_q[k];
    end
    if (shift_win) begin
      for (int k = 0; k < WinDepth - 1; k++) begin
        win_d[k] = win_q[k+1];
      end
      win_d[WinDepth-1] = data_byte_i;
      part8_d[0]        = crc8_byte(Crc8Init, data_byte_i);
      part16_d[0]       = crc16_byte(Crc16Init, data_byte_i);
      for (int k = 1; k < WinDepth; k++) begin
        part8_d[k]  = crc8_byte(part8_q[k-1], data_byte_i);
        part16_d[k] = crc16_byte(part16_q[k-1], data_byte_i);
      end
    end
  end

  always_comb begin
    if (accept) begin
      out_valid_d = emit;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhHunt;
      fill_q      <= 3'd0;
      cnt_q       <= 16'd0;
      len_q       <= 16'd0;
      seq_q       <= 8'h00;
      cmd_q       <= 16'h0000;
      crc16_q     <= Crc16Init;
      crc_lo_q    <= 8'h00;
      fail_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      fill_q      <= fill_d;
      cnt_q       <= cnt_d;
      len_q       <= len_d;
      seq_q       <= seq_d;
      cmd_q       <= cmd_d;
      crc16_q     <= crc16_d;
      crc_lo_q    <= crc_lo_d;
      fail_q      <= fail_d;
      out_valid_q <= out_valid_d;
    end
  end

  // window and partials are only read once the fill count covers them
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < WinDepth; k++) begin
      win_q[k]    <= win_d[k];
      part8_q[k]  <= part8_d[k];
      part16_q[k] <= part16_d[k];
    end
  end

  // result payload, loaded with every accepted item that makes a result
  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      kind_q     <= emit_kind;
      pbyte_q    <= emit_byte;
      idx_q      <= emit_idx;
      res_cmd_q  <= cmd_d;
      res_seq_q  <= seq_d;
      res_len_q  <= len_d;
      res_fail_q <= fail_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign kind_o           = kind_q;
  assign payload_byte_o   = pbyte_q;
  assign byte_index_o     = idx_q;
  assign command_id_o     = res_cmd_q;
  assign sequence_res_o   = res_seq_q;
  assign payload_length_o = res_len_q;
  assign failure_count_o  = res_fail_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  `CFD_ASSERT_NEXT(a_fail_monotonic, 1'b1, fail_q >= $past(fail_q),
    "failure count went down")
  `CFD_ASSERT_NOW(a_status_no_payload, out_valid_q && kind_q != KindPayload,
    pbyte_q == 8'h00 && idx_q == 16'h0000, "status result carries payload data")
  `CFD_ASSERT_NOW(a_hunt_counter_clear, phase_q == PhHunt, cnt_q == 16'd0,
    "byte counter not clear while hunting")
  `CFD_ASSERT_NOW(a_payload_in_range, phase_q == PhPay, cnt_q < len_q,
    "payload index past frame length")

endmodule
